// ===== hdl/rlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rlc_pkg;

	typedef struct packed {
		logic [15:0] base_dwell;
		logic [15:0] red_dwell;
	} cfg_t;

	typedef struct packed {
		logic [7:0] port_a;
		logic [5:0] port_b;
		logic [4:0] port_c;
	} drive_t;

	localparam int unsigned CELL_COUNT = 27;
	localparam logic [3:0] SEL_LAST = 4'd8;
	localparam logic [3:0] COL_LAST = 4'd8;
	localparam logic [3:0] RED_SEL_END = 4'd3;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic REG_BASE_DWELL = 1'b0;
	localparam logic REG_RED_DWELL = 1'b1;

	localparam logic [15:0] BASE_DWELL_RST = 16'd10;
	localparam logic [15:0] RED_DWELL_RST = 16'd20;

	localparam drive_t IDLE_DRIVE = '{port_a: 8'hFF, port_b: 6'h00, port_c: 5'h01};

	// active-low select byte for layer-color lines 1-8 (all high for line 0)
	function automatic logic [7:0] sel_a(input logic [3:0] sel);
		logic [7:0] r;
		case (sel)
			4'd0: r = 8'hFF;
			4'd1: r = 8'hDF;
			4'd2: r = 8'hFB;
			4'd3: r = 8'hBF;
			4'd4: r = 8'hEF;
			4'd5: r = 8'hFD;
			4'd6: r = 8'h7F;
			4'd7: r = 8'hF7;
			4'd8: r = 8'hFE;
			default: r = 8'hFF;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] col_b(input logic [3:0] col);
		logic [5:0] r;
		case (col)
			4'd0: r = 6'h20;
			4'd1: r = 6'h10;
			4'd2: r = 6'h08;
			4'd3: r = 6'h04;
			4'd4: r = 6'h02;
			4'd5: r = 6'h01;
			default: r = 6'h00;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] col_c(input logic [3:0] col);
		logic [4:0] r;
		case (col)
			4'd6: r = 5'h02;
			4'd7: r = 5'h08;
			4'd8: r = 5'h10;
			default: r = 5'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_led_cube_scan_driver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RGB LED cube scan driver, 3x3x3 cells, 81 slots per scan.
// Input channel (in_valid/in_ready): req_type 0 loads three color masks and
// a repeat count and restarts the scan; req_type 1 is one display tick.
// Output channel (out_valid/out_ready): one result per input item with the
// port drive for that tick, busy_res and frame_done.
// Config: APB registers base_dwell (0x0) and red_dwell (0x4); the user must
// write them only while no item is in flight, which the block does not enforce.
// Path: an input transfer loads the input register; the scan step then loads
// the output register, which drives out_valid.
// Throughput: one item per cycle unless out_ready stalls; the scan state update
// is a single combinational step between the input and output registers.
// Reset: masks and scan state clear (idle, all-off drive), dwells go to
// 10 and 20 ticks, both pipeline stages empty.
// Receiver stall: the output register holds, the input register keeps at
// most one more item, then in_ready drops until out_ready returns.

module rgb_led_cube_scan_driver_unit #(
	parameter int unsigned DWELL_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [26:0] red_bits,
	input  wire logic [26:0] green_bits,
	input  wire logic [26:0] blue_bits,
	input  wire logic [7:0]  hold_count,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       port_a,
	output logic [5:0]       port_b,
	output logic [4:0]       port_c,
	output logic             busy_res,
	output logic             frame_done,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	rlc_pkg::cfg_t   cfg;
	rlc_pkg::drive_t step_drive;
	logic            step_busy, step_done;

	logic            v_s1;
	logic            req_type_s1;
	logic [26:0]     red_s1, green_s1, blue_s1;
	logic [7:0]      hold_s1;

	logic            v_s2;
	rlc_pkg::drive_t drive_s2;
	logic            busy_s2, done_s2;

	logic            adv;
	logic            step_en;

	rlc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv      = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv;
	assign step_en  = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			red_s1      <= red_bits;
			green_s1    <= green_bits;
			blue_s1     <= blue_bits;
			hold_s1     <= hold_count;
		end
	end

	rlc_scan_core #(
		.DWELL_WIDTH (DWELL_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.req_type   (req_type_s1),
		.red_bits   (red_s1),
		.green_bits (green_s1),
		.blue_bits  (blue_s1),
		.hold_count (hold_s1),
		.cfg        (cfg),
		.drive      (step_drive),
		.busy_res   (step_busy),
		.frame_done (step_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			drive_s2 <= step_drive;
			busy_s2  <= step_busy;
			done_s2  <= step_done;
		end
	end

	assign out_valid  = v_s2;
	assign port_a     = drive_s2.port_a;
	assign port_b     = drive_s2.port_b;
	assign port_c     = drive_s2.port_c;
	assign busy_res   = busy_s2;
	assign frame_done = done_s2;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && !out_ready))
		else $error("input stalled without a full pipeline");

	a_idle_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !busy_s2) |-> (drive_s2 == rlc_pkg::IDLE_DRIVE))
		else $error("non-busy result with a slot driven");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && done_s2) |-> busy_s2)
		else $error("frame done on a non-busy result");

endmodule

`default_nettype wire

// ===== hdl/rlc_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlc_apb_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output rlc_pkg::cfg_t           cfg
);

	rlc_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_dwell <= rlc_pkg::BASE_DWELL_RST;
			cfg_q.red_dwell  <= rlc_pkg::RED_DWELL_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				rlc_pkg::REG_BASE_DWELL: cfg_q.base_dwell <= pwdata[15:0];
				rlc_pkg::REG_RED_DWELL:  cfg_q.red_dwell  <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rlc_pkg::REG_BASE_DWELL: prdata = {16'h0000, cfg_q.base_dwell};
			rlc_pkg::REG_RED_DWELL:  prdata = {16'h0000, cfg_q.red_dwell};
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/rlc_slot_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlc_slot_decode (
	input  wire logic [3:0]  sel,
	input  wire logic [3:0]  col,
	input  wire logic [26:0] red_mask,
	input  wire logic [26:0] green_mask,
	input  wire logic [26:0] blue_mask,
	output rlc_pkg::drive_t  drive
);

	logic [1:0]  layer;
	logic [26:0] mask;
	logic [31:0] mask_ext;
	logic [4:0]  cell_idx;
	logic        lit;

	// sel = color*3 + layer
	always_comb begin
		case (sel)
			4'd0, 4'd3, 4'd6: layer = 2'd0;
			4'd1, 4'd4, 4'd7: layer = 2'd1;
			default:          layer = 2'd2;
		endcase
		if (sel < 4'd3) begin
			mask = red_mask;
		end else if (sel < 4'd6) begin
			mask = green_mask;
		end else begin
			mask = blue_mask;
		end
	end

	assign cell_idx = 5'(layer) * 5'd9 + 5'(col);
	assign mask_ext = 32'(mask);
	assign lit      = mask_ext[cell_idx];

	always_comb begin
		drive.port_a = rlc_pkg::sel_a(sel);
		drive.port_b = lit ? rlc_pkg::col_b(col) : 6'h00;
		drive.port_c = {(lit ? rlc_pkg::col_c(col) : 5'h00)} | {4'h0, (sel != 4'd0)};
	end

endmodule

`default_nettype wire

// ===== hdl/rlc_scan_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlc_scan_core #(
	parameter int unsigned DWELL_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_en,
	input  wire logic               req_type,
	input  wire logic [26:0]        red_bits,
	input  wire logic [26:0]        green_bits,
	input  wire logic [26:0]        blue_bits,
	input  wire logic [7:0]         hold_count,
	input  wire rlc_pkg::cfg_t      cfg,
	output rlc_pkg::drive_t         drive,
	output logic                    busy_res,
	output logic                    frame_done
);

	localparam int unsigned CMP_W = DWELL_WIDTH + 17;

	logic [26:0]            red_q, green_q, blue_q;
	logic [3:0]             sel_q, col_q;
	logic [DWELL_WIDTH-1:0] cnt_q;
	logic [7:0]             rep_q;

	logic [26:0]            red_d, green_d, blue_d;
	logic [3:0]             sel_d, col_d;
	logic [DWELL_WIDTH-1:0] cnt_d;
	logic [7:0]             rep_d;

	rlc_pkg::drive_t        slot_drive;
	logic [DWELL_WIDTH:0]   cnt_p1;
	logic [15:0]            dwell;
	logic                   slot_end;

	rlc_slot_decode u_decode (
		.sel        (sel_q),
		.col        (col_q),
		.red_mask   (red_q),
		.green_mask (green_q),
		.blue_mask  (blue_q),
		.drive      (slot_drive)
	);

	assign cnt_p1   = {1'b0, cnt_q} + {{DWELL_WIDTH{1'b0}}, 1'b1};
	assign dwell    = (sel_q < rlc_pkg::RED_SEL_END) ? cfg.red_dwell : cfg.base_dwell;
	// zero dwell ends on first tick; dwell past counter range saturates
	assign slot_end = (CMP_W'(cnt_p1) >= CMP_W'(dwell)) || (&cnt_q);

	always_comb begin
		red_d      = red_q;
		green_d    = green_q;
		blue_d     = blue_q;
		sel_d      = sel_q;
		col_d      = col_q;
		cnt_d      = cnt_q;
		rep_d      = rep_q;
		drive      = rlc_pkg::IDLE_DRIVE;
		busy_res   = 1'b0;
		frame_done = 1'b0;
		if (req_type == rlc_pkg::REQ_LOAD) begin
			red_d    = red_bits;
			green_d  = green_bits;
			blue_d   = blue_bits;
			rep_d    = hold_count;
			sel_d    = 4'd0;
			col_d    = 4'd0;
			cnt_d    = '0;
			busy_res = (hold_count != 8'd0);
		end else if (rep_q != 8'd0) begin
			drive    = slot_drive;
			busy_res = 1'b1;
			if (slot_end) begin
				cnt_d = '0;
				if (col_q == rlc_pkg::COL_LAST) begin
					col_d = 4'd0;
					if (sel_q == rlc_pkg::SEL_LAST) begin
						sel_d      = 4'd0;
						rep_d      = rep_q - 8'd1;
						frame_done = (rep_q == 8'd1);
					end else begin
						sel_d = sel_q + 4'd1;
					end
				end else begin
					col_d = col_q + 4'd1;
				end
			end else begin
				cnt_d = cnt_p1[DWELL_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			sel_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
			rep_q   <= '0;
		end else if (step_en) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			sel_q   <= sel_d;
			col_q   <= col_d;
			cnt_q   <= cnt_d;
			rep_q   <= rep_d;
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q <= rlc_pkg::SEL_LAST) && (col_q <= rlc_pkg::COL_LAST))
		else $error("scan position out of range");

	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_q == 8'd0) |-> (sel_q == 4'd0 && col_q == 4'd0 && cnt_q == '0))
		else $error("idle with scan position not at start");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && frame_done) |=> (rep_q == 8'd0))
		else $error("done reported but repeats remain");

endmodule

`default_nettype wire
